// ===== rtl/core/deq_pkg.sv =====
// Shared types, codes and defaults for the double-ended queue.
`default_nettype none

package deq_pkg;

    // Default geometry
    localparam int DEQ_DEPTH      = 16;
    localparam int DEQ_DATA_WIDTH = 32;

    // Fixed widths of the command and response words
    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
    localparam logic [OP_W-1:0] OP_REPLACE    = 3'd5;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Command word
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [VAL_W-1:0] data_in;
    } cmd_t;

    // Response word
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] front_value;
        logic signed [VAL_W-1:0] back_value;
        logic                    is_empty;
        logic [COUNT_W-1:0]      count_out;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;
        logic read;
    } ctl_t;

endpackage : deq_pkg

`default_nettype wire

// ===== rtl/core/deq_ctrl.sv =====
// Sequencing controller: execute, read back ends, respond.
`default_nettype none

module deq_ctrl
    import deq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      done,
    output ctl_t      ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance through execute, read and respond
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Drive commands and handshake
    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_RESP);
    assign ctl.exec = (state_reg == S_IDLE) && start;
    assign ctl.read = (state_reg == S_READ);

endmodule : deq_ctrl

`default_nettype wire

// ===== rtl/core/deq_dp.sv =====
// Datapath: ring buffer store, pointers, count and response word.
`default_nettype none

module deq_dp
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEQ_DEPTH,
    parameter int DATA_WIDTH = DEQ_DATA_WIDTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire ctl_t ctl,
    input  wire cmd_t cmd,
    output rsp_t      rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [PTR_W-1:0]    head_reg, head_next;
    logic [PTR_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DATA_WIDTH-1:0] front_reg, back_reg;

    logic [PTR_W-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic             full, empty;
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic signed [EXT_W-1:0]      din_ext;
    logic [DATA_WIDTH-1:0]        wr_data;
    logic signed [DATA_WIDTH-1:0] front_s, back_s;
    logic signed [EXT_W-1:0]      front_ext, back_ext;
    logic                         rsp_empty;

    // Wrap pointers at the ring depth
    assign head_inc = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? PTR_LAST : head_reg - 1'b1;
    assign tail_inc = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? PTR_LAST : tail_reg - 1'b1;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);

    // Keep the low bits of the sign-extended input value
    assign din_ext = EXT_W'(cmd.data_in);
    assign wr_data = din_ext[DATA_WIDTH-1:0];

    // Decode the operation into pointer, count and store updates
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        status_next = STAT_OK;
        wr_en       = 1'b0;
        wr_addr     = tail_reg;
        unique case (cmd.operation)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    head_next  = head_dec;
                    wr_addr    = head_dec;
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    tail_next  = tail_inc;
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    tail_next  = tail_dec;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            OP_REPLACE:
            begin
                // Push always lands: a full ring frees a slot by the pop
                tail_next = tail_inc;
                wr_en     = 1'b1;
                if (empty)
                begin
                    status_next = STAT_EMPTY;
                    count_next  = count_reg + 1'b1;
                end
                else
                begin
                    head_next = head_inc;
                end
            end
            default:
            begin
                status_next = STAT_OK;
            end
        endcase
    end

    // Hold pointers, count and status between operations
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            count_reg  <= '0;
            status_reg <= STAT_OK;
        end
        else if (ctl.exec)
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Write the pushed word
    always_ff @(posedge clk)
    begin
        if (ctl.exec && wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read front and back words after the pointers settle
    always_ff @(posedge clk)
    begin
        if (ctl.read)
        begin
            front_reg <= mem[head_reg];
            back_reg  <= mem[tail_dec];
        end
    end

    // Sign-extend stored words and zero them when the ring is empty
    assign front_s   = front_reg;
    assign back_s    = back_reg;
    assign front_ext = EXT_W'(front_s);
    assign back_ext  = EXT_W'(back_s);
    assign rsp_empty = (count_reg == '0);

    assign rsp.status      = status_reg;
    assign rsp.front_value = rsp_empty ? '0 : front_ext[VAL_W-1:0];
    assign rsp.back_value  = rsp_empty ? '0 : back_ext[VAL_W-1:0];
    assign rsp.is_empty    = rsp_empty;
    assign rsp.count_out   = COUNT_W'(count_reg);

endmodule : deq_dp

`default_nettype wire

// ===== rtl/core/double_ended_queue.sv =====
// After start is taken, the store's registered read of the front and back
// entries follows the pointer update in the read state, and done strobes the
// response word in the respond state. No new operation is taken until idle.
// The receiver cannot stall; each response is shown for exactly one cycle.
// Reset clears pointers, count and controller state; the store is not cleared.
`default_nettype none

module double_ended_queue
    import deq_pkg::*;
#(
    parameter int DEPTH      = DEQ_DEPTH,
    parameter int DATA_WIDTH = DEQ_DATA_WIDTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire cmd_t cmd,
    output logic      done,
    output rsp_t      rsp
);

    ctl_t ctl;

    // Sequence each operation
    deq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // Store and pointer datapath
    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .cmd   (cmd),
        .rsp   (rsp)
    );

endmodule : double_ended_queue

`default_nettype wire

// ===== rtl/core/deq_checker.sv =====
// Port-level checker for the double-ended queue, bound to the top level.
`default_nettype none

module deq_port_checker
    import deq_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done,
    input wire rsp_t rsp
);

    // Response word follows an accepted command through the read and respond states
    a_resp_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("response not strobed two cycles after accept");

    // No command is taken while a response is shown
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done strobed while idle");

    // Empty flag agrees with the count
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.is_empty == (rsp.count_out == '0)))
        else $error("empty flag disagrees with count");

    // Empty ring reports zero end values
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.is_empty) |-> (rsp.front_value == '0 && rsp.back_value == '0))
        else $error("nonzero end value on empty ring");

    // Status stays among the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == STAT_OK || rsp.status == STAT_EMPTY ||
                  rsp.status == STAT_FULL))
        else $error("undefined status code");

endmodule : deq_port_checker

bind double_ended_queue deq_port_checker u_deq_checker (.*);

`default_nettype wire

// ===== dv/deq_checker.sv =====
// Response checker for the double-ended queue: predicts every response word and compares it.
module deq_checker
    import deq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire cmd_t cmd,
    input  wire logic done,
    input  wire rsp_t rsp,
    output int        fails,
    output int        pending,
    output int        checked,
    output int        rejects
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the deque contents and pointers
    logic signed [VAL_W-1:0] ring [DEQ_DEPTH];
    int unsigned             front_idx;
    int unsigned             end_idx;
    int unsigned             fill;

    // Response words still owed by the block, oldest first
    rsp_t                    owed_rsp [$];

    function automatic int unsigned step_up(int unsigned p);
        return (p + 1 >= DEQ_DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int unsigned step_down(int unsigned p);
        return (p == 0) ? DEQ_DEPTH - 1 : p - 1;
    endfunction

    function automatic logic [STATUS_W-1:0] add_at_front(logic signed [VAL_W-1:0] v);
        if (fill >= DEQ_DEPTH)
            return STAT_FULL;
        front_idx = step_down(front_idx);
        ring[front_idx] = v;
        fill++;
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] add_at_back(logic signed [VAL_W-1:0] v);
        if (fill >= DEQ_DEPTH)
            return STAT_FULL;
        ring[end_idx] = v;
        end_idx = step_up(end_idx);
        fill++;
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] drop_front();
        if (fill == 0)
            return STAT_EMPTY;
        front_idx = step_up(front_idx);
        fill--;
        return STAT_OK;
    endfunction

    function automatic logic [STATUS_W-1:0] drop_back();
        if (fill == 0)
            return STAT_EMPTY;
        end_idx = step_down(end_idx);
        fill--;
        return STAT_OK;
    endfunction

    // Apply one command word to the shadow deque and return the response it earns
    function automatic rsp_t deque_after(cmd_t c);
        rsp_t r;
        r = '0;
        r.status = STAT_OK;
        case (c.operation)
            OP_PUSH_FRONT: r.status = add_at_front(c.data_in);
            OP_PUSH_BACK:  r.status = add_at_back(c.data_in);
            OP_POP_FRONT:  r.status = drop_front();
            OP_POP_BACK:   r.status = drop_back();
            OP_CLEAR:
            begin
                front_idx = 0;
                end_idx   = 0;
                fill      = 0;
            end
            OP_REPLACE:
            begin
                // pop may fail on an empty deque, the push still goes in
                r.status = drop_front();
                if (add_at_back(c.data_in) != STAT_OK)
                    r.status = STAT_FULL;
            end
            default: ;
        endcase
        if (fill != 0)
        begin
            r.front_value = ring[front_idx];
            r.back_value  = ring[step_down(end_idx)];
        end
        r.is_empty  = (fill == 0);
        r.count_out = COUNT_W'(fill);
        return r;
    endfunction

    task automatic flag(input string why, input rsp_t want, input rsp_t got);
        fails++;
        if (fails <= 10)
            $display("%0t deq_checker: %s: want st=%0d front=%0d back=%0d empty=%0b count=%0d,",
                     $realtime, why, want.status, want.front_value, want.back_value,
                     want.is_empty, want.count_out,
                     "  got st=%0d front=%0d back=%0d empty=%0b count=%0d",
                     got.status, got.front_value, got.back_value, got.is_empty, got.count_out);
    endtask

    // Compare the strobed word first, then predict the command taken at this edge
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            front_idx = 0;
            end_idx   = 0;
            fill      = 0;
            fails     = 0;
            checked   = 0;
            rejects   = 0;
            owed_rsp.delete();
            pending  <= 0;
        end
        else
        begin
            if (done)
            begin
                checked++;
                if (owed_rsp.size() == 0)
                    flag("response with nothing outstanding", '0, rsp);
                else
                begin
                    want = owed_rsp.pop_front();
                    if (want.status != STAT_OK)
                        rejects++;
                    if (rsp.status !== want.status || rsp.front_value !== want.front_value ||
                        rsp.back_value !== want.back_value || rsp.is_empty !== want.is_empty ||
                        rsp.count_out !== want.count_out)
                        flag("response mismatch", want, rsp);
                end
            end
            if (start && !busy)
            begin
                want = deque_after(cmd);
                owed_rsp.push_back(want);
            end
            pending <= owed_rsp.size();
        end
    end

endmodule

// ===== dv/tb_double_ended_queue.sv =====
// Testbench top for the double-ended queue: clock, reset, command stimulus and verdict.
module tb_double_ended_queue
    import deq_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Operation codes the block leaves undefined
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    localparam int N_RANDOM = 1625;
    localparam int WATCHDOG = 1000;

    typedef enum int {MOOD_FILL, MOOD_DRAIN, MOOD_CHURN, MOOD_NOISE} mood_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic done;
    rsp_t rsp;

    int   fails;
    int   pending;
    int   checked;
    int   rejects;
    int   quiet = 0;
    int   op_hits [8];

    always #1 clk = ~clk;

    double_ended_queue u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .done  (done),
        .rsp   (rsp)
    );

    deq_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .rsp     (rsp),
        .fails   (fails),
        .pending (pending),
        .checked (checked),
        .rejects (rejects)
    );

    // Abort when no word moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet <= 0;
        else if (quiet >= WATCHDOG)
        begin
            $display("[double_ended_queue] ERROR");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Hold off for the given gap, then present one command word until it is taken
    task automatic issue(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] val,
                         input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= '{operation: op, data_in: val};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        op_hits[op]++;
    endtask

    // Drop start and wait until every response owed has come back
    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(mood_t mood);
        int r;
        r = $urandom_range(0, 99);
        case (mood)
            MOOD_FILL:
                if (r < 40)      return OP_PUSH_FRONT;
                else if (r < 80) return OP_PUSH_BACK;
                else if (r < 88) return OP_POP_FRONT;
                else if (r < 95) return OP_POP_BACK;
                else             return OP_REPLACE;
            MOOD_DRAIN:
                if (r < 40)      return OP_POP_FRONT;
                else if (r < 80) return OP_POP_BACK;
                else if (r < 88) return OP_PUSH_FRONT;
                else if (r < 94) return OP_PUSH_BACK;
                else if (r < 98) return OP_REPLACE;
                else             return OP_CLEAR;
            MOOD_CHURN:
                if (r < 50)      return OP_REPLACE;
                else if (r < 62) return OP_PUSH_FRONT;
                else if (r < 74) return OP_PUSH_BACK;
                else if (r < 87) return OP_POP_FRONT;
                else             return OP_POP_BACK;
            default:
                return OP_W'($urandom_range(0, 7));
        endcase
    endfunction

    initial
    begin
        int               n_rand;
        int               run;
        int               pick;
        bit               steady;
        bit               all_ops;
        mood_t            mood;
        logic [OP_W-1:0]  op;

        foreach (op_hits[i])
            op_hits[i] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty pops, spare codes, replace on empty, fill to full, full cases
        issue(OP_POP_FRONT, pick_value(), $urandom_range(0, 12));
        issue(OP_POP_BACK, pick_value(), $urandom_range(0, 12));
        issue(OP_SPARE_6, pick_value(), $urandom_range(0, 12));
        issue(OP_SPARE_7, pick_value(), $urandom_range(0, 12));
        issue(OP_REPLACE, VAL_MIN, $urandom_range(0, 12));
        for (int i = 0; i < DEQ_DEPTH - 1; i++)
            issue((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK,
                  (i == 0) ? VAL_MAX : (i == 1) ? VAL_MIN : (i == 2) ? '0 :
                  (i == 3) ? '1 : $urandom, $urandom_range(0, 12));
        issue(OP_PUSH_BACK, pick_value(), $urandom_range(0, 12));
        issue(OP_PUSH_FRONT, pick_value(), $urandom_range(0, 12));
        issue(OP_REPLACE, pick_value(), $urandom_range(0, 12));
        issue(OP_POP_BACK, pick_value(), $urandom_range(0, 12));
        issue(OP_POP_FRONT, pick_value(), $urandom_range(0, 12));
        issue(OP_CLEAR, pick_value(), $urandom_range(0, 12));
        settle();

        // Random: runs of filling, draining, churning or noise with varied pacing
        n_rand = 0;
        while (n_rand < N_RANDOM)
        begin
            pick   = $urandom_range(0, 9);
            mood   = (pick < 3) ? MOOD_FILL : (pick < 6) ? MOOD_DRAIN :
                     (pick < 9) ? MOOD_CHURN : MOOD_NOISE;
            steady = ($urandom_range(0, 3) == 0);
            run    = $urandom_range(8, 40);
            if ($urandom_range(0, 9) == 0)
                settle();
            repeat (run)
            begin
                op = pick_op(mood);
                issue(op, pick_value(), steady ? 0 : $urandom_range(0, 12));
                if (op <= OP_REPLACE)
                    n_rand++;
            end
        end

        settle();
        repeat (4) @(posedge clk);

        all_ops = 1'b1;
        foreach (op_hits[i])
            if (op_hits[i] == 0)
                all_ops = 1'b0;
        $display("Summary: %0d commands sent, all eight op codes used: %0s",
                 op_hits.sum(), all_ops ? "yes" : "no");
        $display("Summary: %0d responses checked, %0d carried an empty or full status",
                 checked, rejects);
        if (pending != 0)
            $display("%0d responses never arrived", pending);

        if (fails == 0 && pending == 0)
            $display("[double_ended_queue] OK");
        else
            $display("[double_ended_queue] ERROR");
        $finish;
    end

endmodule
